/* hdl/vbfc_pkg.sv */
// Package: shared types and constants for the bf16/fp32 vector convert.
`timescale 1ns / 1ps
package vbfc_pkg;

    localparam int unsigned NumElems = 4;

    localparam logic [4:0] FlagInvalid   = 5'h10;
    localparam logic [4:0] FlagOverflow  = 5'h04;
    localparam logic [4:0] FlagUnderflow = 5'h02;
    localparam logic [4:0] FlagInexact   = 5'h01;

    localparam logic        KindWiden  = 1'b0;
    localparam logic        KindNarrow = 1'b1;

    localparam logic [2:0] RmNearEven = 3'd0;
    localparam logic [2:0] RmTowardZero = 3'd1;
    localparam logic [2:0] RmDown     = 3'd2;
    localparam logic [2:0] RmUp       = 3'd3;
    localparam logic [2:0] RmNearMax  = 3'd4;

    localparam logic [31:0] Fp32CanonNan = 32'h7FC0_0000;
    localparam logic [15:0] Bf16CanonNan = 16'h7FC0;
    localparam logic [31:0] Ones32 = 32'hFFFF_FFFF;
    localparam logic [15:0] Ones16 = 16'hFFFF;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic [4:0]  exception_flags;
    } vbfc_res_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] source_low;
        logic [63:0] source_high;
        logic [63:0] old_low;
        logic [63:0] old_high;
        logic [3:0]  mask_bits;
        logic [2:0]  round_mode;
        logic [6:0]  start_index;
        logic [7:0]  vector_length;
        logic        mask_agnostic;
        logic        tail_agnostic;
        logic        masked;
    } vbfc_req_t;

endpackage

/* hdl/vbfc_if.sv */
// Interface: valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps
interface vbfc_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/vbfc_elem.sv */
// Per-element widen and narrow datapath with flags.
`timescale 1ns / 1ps
module vbfc_elem
    import vbfc_pkg::*;
(
    input  logic        kind,
    input  logic [31:0] src,
    input  logic [2:0]  round_mode,
    output logic [31:0] value,
    output logic [4:0]  flags
);
    logic [15:0] h;
    logic        sign;
    logic [30:0] absv;
    logic [14:0] mag;
    logic [15:0] rem;
    logic        inexact;
    logic        up;
    logic [15:0] mag_r;
    logic [14:0] inc;
    logic [31:0] tiny_sum;
    logic        to_inf;

    always_comb
    begin
        h        = src[15:0];
        sign     = src[31];
        absv     = src[30:0];
        mag      = absv[30:16];
        rem      = absv[15:0];
        inexact  = (rem != 16'd0);
        flags    = 5'd0;
        value    = 32'd0;
        up       = 1'b0;
        inc      = 15'd0;
        to_inf   = 1'b0;
        case (round_mode)
            RmNearEven: up = (rem > 16'h8000) || ((rem == 16'h8000) && mag[0]);
            RmDown:     up = sign && inexact;
            RmUp:       up = !sign && inexact;
            RmNearMax:  up = (rem >= 16'h8000);
            default:    up = 1'b0;
        endcase
        case (round_mode)
            RmNearEven, RmNearMax: inc = 15'h4000;
            RmDown:  inc = sign ? 15'h7FFF : 15'd0;
            RmUp:    inc = sign ? 15'd0 : 15'h7FFF;
            default: inc = 15'd0;
        endcase
        case (round_mode)
            RmNearEven, RmNearMax: to_inf = 1'b1;
            RmDown:  to_inf = sign;
            RmUp:    to_inf = !sign;
            default: to_inf = 1'b0;
        endcase
        tiny_sum = {1'b0, absv} + {17'd0, inc};
        mag_r    = {1'b0, mag} + {15'd0, up};

        if (kind == KindWiden)
        begin
            if ((h[14:7] == 8'hFF) && (h[6:0] != 7'd0))
            begin
                value = Fp32CanonNan;
                if (!h[6])
                    flags = FlagInvalid;
            end
            else
                value = {h, 16'd0};
        end
        else if (absv > 31'h7F80_0000)
        begin
            value = {16'd0, Bf16CanonNan};
            if (!absv[22])
                flags = FlagInvalid;
        end
        else if (absv == 31'h7F80_0000)
            value = {16'd0, sign, 15'h7F80};
        else
        begin
            if ((absv[30:23] == 8'd0) && inexact && (tiny_sum < 32'h0080_0000))
                flags = flags | FlagUnderflow;
            if (mag_r >= 16'h7F80)
            begin
                flags = flags | FlagOverflow | FlagInexact;
                value = {16'd0, sign, to_inf ? 15'h7F80 : 15'h7F7F};
            end
            else
            begin
                if (inexact)
                    flags = flags | FlagInexact;
                value = {16'd0, sign, mag_r[14:0]};
            end
        end
    end
endmodule

/* hdl/vector_bf16_fp32_convert_core.sv */
// Top level: registered single-pass bf16/fp32 vector convert.
// Datapath: the input word is captured in the input register, and its result is then captured
// in the result register and offered from there; a full result slot can hold it in between.
// Throughput: one word per cycle; the result register and input register form
// a two-stage pipeline that advances whenever the result slot is free or drained.
// Reset: rst_n asynchronously clears both stage valid bits; payload is not reset.
`timescale 1ns / 1ps
module vector_bf16_fp32_convert_core
    import vbfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vbfc_if.sink   in_ch,
    vbfc_if.source out_ch
);
    // Stage 1: input register.
    vbfc_req_t  req_reg;
    logic       s1_valid_reg, s1_valid_next;
    // Stage 2: result register.
    vbfc_res_t  res_reg, res_next;
    logic       s2_valid_reg, s2_valid_next;

    logic s2_ready, s1_ready;

    // Advance the result slot when empty or drained; advance stage 1 likewise.
    assign s2_ready     = !s2_valid_reg || out_ch.ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign in_ch.ready  = s1_ready;
    assign out_ch.valid = s2_valid_reg;
    assign out_ch.data  = res_reg;

    assign s1_valid_next = in_ch.valid ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s1_valid_reg ? 1'b1 : (out_ch.ready ? 1'b0 : s2_valid_reg);

    // Element conversions, four lanes in parallel.
    logic [31:0] conv_val [NumElems];
    logic [4:0]  conv_flg [NumElems];
    logic [31:0] lane_src [NumElems];

    for (genvar g = 0; g < NumElems; g++)
    begin : g_lane
        assign lane_src[g] = (req_reg.kind == KindWiden)
            ? {16'd0, req_reg.source_low[16*g +: 16]}
            : ((g < 2) ? req_reg.source_low[32*(g%2) +: 32]
                       : req_reg.source_high[32*(g%2) +: 32]);
        vbfc_elem u_elem (
            .kind       (req_reg.kind),
            .src        (lane_src[g]),
            .round_mode (req_reg.round_mode),
            .value      (conv_val[g]),
            .flags      (conv_flg[g])
        );
    end

    // Classify each element and merge with the old destination.
    always_comb
    begin
        logic [31:0] oldv, ones, val;
        logic        body, vmask;
        res_next = '0;
        for (int i = 0; i < NumElems; i++)
        begin
            if (req_reg.kind == KindWiden)
            begin
                oldv = (i < 2) ? req_reg.old_low[32*(i%2) +: 32]
                               : req_reg.old_high[32*(i%2) +: 32];
                ones = Ones32;
            end
            else
            begin
                oldv = {16'd0, req_reg.old_low[16*i +: 16]};
                ones = {16'd0, Ones16};
            end
            body  = ({1'b0, req_reg.start_index} <= 8'(i)) && (8'(i) < req_reg.vector_length);
            vmask = req_reg.masked && !req_reg.mask_bits[i];
            if (body)
            begin
                if (vmask)
                    val = req_reg.mask_agnostic ? ones : oldv;
                else
                begin
                    val = conv_val[i];
                    res_next.exception_flags = res_next.exception_flags | conv_flg[i];
                end
            end
            else if ((8'(i) < {1'b0, req_reg.start_index}) || !req_reg.tail_agnostic ||
                     ({1'b0, req_reg.start_index} >= req_reg.vector_length))
                val = oldv;
            else
                val = ones;
            if (req_reg.kind == KindWiden)
            begin
                if (i < 2)
                    res_next.result_low[32*(i%2) +: 32] = val;
                else
                    res_next.result_high[32*(i%2) +: 32] = val;
            end
            else
                res_next.result_low[16*i +: 16] = val[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s1_valid_next;
            if (s2_ready)
                s2_valid_reg <= s2_valid_next;
        end
    end

    // Hold payload unless the stage advances.
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_ch.valid)
            req_reg <= in_ch.data;
        if (s2_ready && s1_valid_reg)
            res_reg <= res_next;
    end

    // A narrowing result never carries upper bits.
    a_narrow_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_ready && s1_valid_reg && req_reg.kind == KindNarrow) |=> (res_reg.result_high == 64'd0))
        else $error("narrow result has nonzero high half");
    // Divide-by-zero is never raised.
    a_no_divzero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (res_reg.exception_flags[3] == 1'b0))
        else $error("divzero flag set");
    // A word in stage 1 moves to the result register when that slot is free.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_valid_reg) |=> s2_valid_reg)
        else $error("stage 1 word did not advance");
endmodule
